/* hdl/epps_pkg.sv */
package epps_pkg;

    localparam int IMAGE_SIDE  = 2048;
    localparam int QBITS       = 40;
    localparam int PIX_W       = 11;
    localparam int COORD_W     = 48;
    localparam int STEP_W      = 47;
    localparam int RAD_W       = 7;
    localparam int CNT_W       = 20;
    localparam int LOG_W       = 32;
    localparam int SHADE_W     = 8;
    localparam int SHADE_BITS  = 8;
    localparam int LFRAC_BITS  = 27;
    localparam int Z_W         = 50;
    localparam int ZP_W        = 60;
    localparam int MAP_W       = PIX_W + STEP_W;
    localparam int OP_W        = 64;
    localparam int DIG_W       = 32;
    localparam int PROD_W      = 2 * OP_W;
    localparam int MUL_CELLS   = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_X_MIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_MAX      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_X     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_Y     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_SQ  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIMIT = 3'd5;

    localparam logic signed [COORD_W-1:0] X_MIN_RST  = -48'sd2803754650829;
    localparam logic signed [COORD_W-1:0] Y_MAX_RST  = 48'sd1979120929997;
    localparam logic [STEP_W-1:0]         STEP_RST   = 47'd1980110985;
    localparam logic [RAD_W-1:0]          RADIUS_RST = 7'd100;
    localparam logic [CNT_W-1:0]          LIMIT_RST  = 20'd90000;

    localparam logic [1:0] TAG_RR = 2'd0;
    localparam logic [1:0] TAG_II = 2'd1;
    localparam logic [1:0] TAG_RI = 2'd2;
    localparam logic [1:0] TAG_SQ = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] y_max;
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
        logic [RAD_W-1:0]          radius_sq;
        logic [CNT_W-1:0]          iter_limit;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        tag;
        logic              neg;
        logic [1:0]        step;
        logic [OP_W-1:0]   a;
        logic [OP_W-1:0]   b;
        logic [PROD_W-1:0] acc;
    } mul_t;

    typedef struct packed {
        logic               interior;
        logic [CNT_W-1:0]   count;
        logic [LOG_W-1:0]   lval;
        logic [SHADE_W-1:0] shade;
    } res_t;

    typedef logic [SHADE_W-1:0] shade_tab_t [0:(1 << SHADE_BITS)-1];

    // quotient of a non-negative value by a positive one, shift and subtract
    function automatic longint quot_pos(longint num, longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // cosine by truncated Taylor series, folded by quadrant
    function automatic shade_tab_t build_shades();
        shade_tab_t tab;
        longint pi28;
        longint one;
        longint r;
        longint x;
        longint x2;
        longint tc;
        longint cs;
        longint ts;
        longint sn;
        longint v;
        longint num;
        int q;
        pi28 = 64'sd843314857;
        one  = 64'sd1 <<< 28;
        for (int k = 0; k < (1 << SHADE_BITS); k++)
        begin
            q  = k >> (SHADE_BITS - 2);
            r  = longint'(k & ((1 << (SHADE_BITS - 2)) - 1));
            x  = (pi28 * r) >>> (SHADE_BITS - 1);
            x2 = (x * x) >>> 28;
            tc = one;
            cs = one;
            ts = x;
            sn = x;
            for (int i = 1; i <= 10; i++)
            begin
                tc = quot_pos((tc * x2) >>> 28, longint'((2 * i - 1) * (2 * i)));
                ts = quot_pos((ts * x2) >>> 28, longint'((2 * i) * (2 * i + 1)));
                cs = ((i & 1) != 0) ? cs - tc : cs + tc;
                sn = ((i & 1) != 0) ? sn - ts : sn + ts;
            end
            case (q)
                0:       v = cs;
                1:       v = -sn;
                2:       v = -cs;
                default: v = sn;
            endcase
            num = 64'sd255 * (one + v);
            if (num < 0)
            begin
                num = 0;
            end
            num = num >>> 29;
            tab[k] = (num > 255) ? 8'd255 : 8'(num);
        end
        return tab;
    endfunction

    localparam shade_tab_t SHADE_TAB = build_shades();

endpackage

/* hdl/epps_mul_cell.sv */
module epps_mul_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  epps_pkg::mul_t din,
    output epps_pkg::mul_t dout
);

    logic                         valid_reg;
    epps_pkg::mul_t               data_reg;
    epps_pkg::mul_t               data_next;
    logic [epps_pkg::DIG_W-1:0]   a_dig;
    logic [epps_pkg::DIG_W-1:0]   b_dig;
    logic [2*epps_pkg::DIG_W-1:0] pp;
    logic [epps_pkg::PROD_W-1:0]  pp_sh;

    // one 32x32 partial product per cell, picked by the step the item carries
    always_comb
    begin
        a_dig = din.step[1] ? din.a[2*epps_pkg::DIG_W-1:epps_pkg::DIG_W]
                            : din.a[epps_pkg::DIG_W-1:0];
        b_dig = din.step[0] ? din.b[2*epps_pkg::DIG_W-1:epps_pkg::DIG_W]
                            : din.b[epps_pkg::DIG_W-1:0];
        pp    = a_dig * b_dig;
        case (din.step)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        data_next      = din;
        data_next.acc  = din.acc + pp_sh;
        data_next.step = din.step + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

/* hdl/epps_mul_chain.sv */
module epps_mul_chain
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [epps_pkg::OP_W-1:0]   a,
    input  logic [epps_pkg::OP_W-1:0]   b,
    input  logic                        neg,
    input  logic [1:0]                  tag,
    output epps_pkg::mul_t              result
);

    epps_pkg::mul_t link [0:epps_pkg::MUL_CELLS];

    always_comb
    begin
        link[0].valid = go;
        link[0].tag   = tag;
        link[0].neg   = neg;
        link[0].step  = 2'd0;
        link[0].a     = a;
        link[0].b     = b;
        link[0].acc   = '0;
    end

    for (genvar g = 0; g < epps_pkg::MUL_CELLS; g++)
    begin : g_cell
        epps_mul_cell u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (link[g]),
            .dout (link[g+1])
        );
    end

    assign result = link[epps_pkg::MUL_CELLS];

endmodule

/* hdl/epps_core.sv */
module epps_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  epps_pkg::cfg_t               cfg,
    input  logic                         start,
    input  logic [epps_pkg::PIX_W-1:0]   px,
    input  logic [epps_pkg::PIX_W-1:0]   py,
    output logic                         idle,
    output logic                         res_valid,
    output epps_pkg::res_t               res,
    input  logic                         res_take
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAP1  = 4'd1;
    localparam logic [3:0] S_MAP2  = 4'd2;
    localparam logic [3:0] S_ISSUE = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_NORM  = 4'd6;
    localparam logic [3:0] S_LSQ   = 4'd7;
    localparam logic [3:0] S_LWAIT = 4'd8;
    localparam logic [3:0] S_LFIN  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [epps_pkg::PIX_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [epps_pkg::MAP_W-1:0] mapx_reg, mapx_next, mapy_reg, mapy_next;
    logic signed [epps_pkg::COORD_W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [epps_pkg::Z_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [epps_pkg::ZP_W-1:0] rr_reg, rr_next, ii_reg, ii_next, ri_reg, ri_next;
    logic [epps_pkg::CNT_W-1:0] count_reg, count_next;
    logic [1:0] iss_reg, iss_next;
    logic [epps_pkg::OP_W-1:0] m_reg, m_next;
    logic [5:0] p_reg, p_next;
    logic [epps_pkg::LFRAC_BITS-1:0] f_reg, f_next;
    logic [4:0] bit_reg, bit_next;
    logic pass_reg, pass_next;
    epps_pkg::res_t res_reg, res_next;

    logic                        mul_go;
    logic [epps_pkg::OP_W-1:0]   mul_a;
    logic [epps_pkg::OP_W-1:0]   mul_b;
    logic                        mul_neg;
    logic [1:0]                  mul_tag;
    epps_pkg::mul_t              mo;

    logic [epps_pkg::ZP_W-1:0]   q_mag;
    logic [epps_pkg::ZP_W-1:0]   q_val;
    logic [epps_pkg::OP_W-1:0]   sq;
    logic [epps_pkg::Z_W-1:0]    zr_abs;
    logic [epps_pkg::Z_W-1:0]    zi_abs;
    logic [epps_pkg::PIX_W-1:0]  px_c;
    logic [epps_pkg::PIX_W-1:0]  py_c;
    logic signed [59:0]          ci_full;
    logic signed [59:0]          cr_full;
    logic [59:0]                 ci_abs;
    logic [60:0]                 norm;
    logic [60:0]                 bail;
    logic signed [60:0]          zr_sum;
    logic signed [60:0]          zi_sum;
    logic [5:0]                  lexp;
    logic [4:0]                  nbits;
    logic [epps_pkg::LOG_W-1:0]  lval;

    epps_mul_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .neg   (mul_neg),
        .tag   (mul_tag),
        .result(mo)
    );

    // floor of a signed Q.40 product from the magnitude product
    always_comb
    begin
        q_mag = mo.acc[epps_pkg::QBITS +: epps_pkg::ZP_W]
              + epps_pkg::ZP_W'(mo.neg && (mo.acc[epps_pkg::QBITS-1:0] != '0));
        q_val = mo.neg ? (~q_mag + 1'b1) : q_mag;
        sq    = mo.acc[125:62];
    end

    always_comb
    begin
        zr_abs = zr_reg[epps_pkg::Z_W-1] ? -zr_reg : zr_reg;
        zi_abs = zi_reg[epps_pkg::Z_W-1] ? -zi_reg : zi_reg;

        px_c = (32'(px) > epps_pkg::IMAGE_SIDE - 1) ?
               epps_pkg::PIX_W'(epps_pkg::IMAGE_SIDE - 1) : px;
        py_c = (32'(py) > epps_pkg::IMAGE_SIDE - 1) ?
               epps_pkg::PIX_W'(epps_pkg::IMAGE_SIDE - 1) : py;

        ci_full = {{12{cfg.y_max[47]}}, cfg.y_max} - $signed({2'b0, mapy_reg});
        cr_full = {{12{cfg.x_min[47]}}, cfg.x_min} + $signed({2'b0, mapx_reg});
        ci_abs  = ci_full[59] ? 60'(-ci_full) : 60'(ci_full);

        norm   = {1'b0, rr_reg} + {1'b0, ii_reg};
        bail   = {14'd0, cfg.radius_sq, 40'd0};
        zr_sum = {rr_reg[59], rr_reg} - {ii_reg[59], ii_reg}
               + {{13{cr_reg[47]}}, cr_reg};
        zi_sum = {ri_reg, 1'b0} + {{13{ci_reg[47]}}, ci_reg};

        lexp  = p_reg - 6'd40;
        nbits = pass_reg ? 5'(epps_pkg::SHADE_BITS) : 5'(epps_pkg::LFRAC_BITS);
        lval  = (p_reg < 6'd40) ? '0 : {lexp[4:0], f_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        mapx_next  = mapx_reg;
        mapy_next  = mapy_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        ri_next    = ri_reg;
        count_next = count_reg;
        iss_next   = iss_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        f_next     = f_reg;
        bit_next   = bit_reg;
        pass_next  = pass_reg;
        res_next   = res_reg;
        mul_go     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_neg    = 1'b0;
        mul_tag    = epps_pkg::TAG_RR;

        if (mo.valid)
        begin
            case (mo.tag)
                epps_pkg::TAG_RR: rr_next = $signed(q_val);
                epps_pkg::TAG_II: ii_next = $signed(q_val);
                epps_pkg::TAG_RI: ri_next = $signed(q_val);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = px_c;
                    py_next    = py_c;
                    state_next = S_MAP1;
                end
            end
            S_MAP1:
            begin
                mapx_next  = px_reg * cfg.step_x;
                mapy_next  = py_reg * cfg.step_y;
                state_next = S_MAP2;
            end
            S_MAP2:
            begin
                // snap to the real axis within half a step, then saturate
                if ({ci_abs, 1'b0} < {14'd0, cfg.step_y})
                begin
                    ci_next = '0;
                end
                else if (ci_full > 60'sh000_7FFF_FFFF_FFFF)
                begin
                    ci_next = 48'sh7FFFFFFFFFFF;
                end
                else if (ci_full < -60'sh000_8000_0000_0000)
                begin
                    ci_next = 48'sh800000000000;
                end
                else
                begin
                    ci_next = ci_full[47:0];
                end
                if (cr_full > 60'sh000_7FFF_FFFF_FFFF)
                begin
                    cr_next = 48'sh7FFFFFFFFFFF;
                end
                else if (cr_full < -60'sh000_8000_0000_0000)
                begin
                    cr_next = 48'sh800000000000;
                end
                else
                begin
                    cr_next = cr_full[47:0];
                end
                zr_next    = '0;
                zi_next    = '0;
                count_next = '0;
                iss_next   = 2'd0;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                mul_go = 1'b1;
                case (iss_reg)
                    2'd0:
                    begin
                        mul_a   = {14'd0, zr_abs};
                        mul_b   = {14'd0, zr_abs};
                        mul_tag = epps_pkg::TAG_RR;
                    end
                    2'd1:
                    begin
                        mul_a   = {14'd0, zi_abs};
                        mul_b   = {14'd0, zi_abs};
                        mul_tag = epps_pkg::TAG_II;
                    end
                    default:
                    begin
                        mul_a   = {14'd0, zr_abs};
                        mul_b   = {14'd0, zi_abs};
                        mul_neg = zr_reg[epps_pkg::Z_W-1] ^ zi_reg[epps_pkg::Z_W-1];
                        mul_tag = epps_pkg::TAG_RI;
                    end
                endcase
                if (iss_reg == 2'd2)
                begin
                    iss_next   = 2'd0;
                    state_next = S_WAIT;
                end
                else
                begin
                    iss_next = iss_reg + 2'd1;
                end
            end
            S_WAIT:
            begin
                if (mo.valid && mo.tag == epps_pkg::TAG_RI)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (norm > bail)
                begin
                    m_next         = {3'd0, norm};
                    p_next         = 6'd62;
                    f_next         = '0;
                    bit_next       = '0;
                    pass_next      = 1'b0;
                    res_next.count = count_reg;
                    state_next     = S_NORM;
                end
                else if (count_reg == cfg.iter_limit)
                begin
                    res_next.interior = 1'b1;
                    res_next.count    = '0;
                    res_next.lval     = '0;
                    res_next.shade    = '0;
                    state_next        = S_DONE;
                end
                else
                begin
                    zr_next    = zr_sum[epps_pkg::Z_W-1:0];
                    zi_next    = zi_sum[epps_pkg::Z_W-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_NORM:
            begin
                // bring the top set bit to bit 62, one place a cycle
                if (m_reg[63])
                begin
                    m_next     = m_reg >> 1;
                    p_next     = 6'd63;
                    state_next = S_LSQ;
                end
                else if (m_reg[62])
                begin
                    state_next = S_LSQ;
                end
                else
                begin
                    m_next = m_reg << 1;
                    p_next = p_reg - 6'd1;
                end
            end
            S_LSQ:
            begin
                mul_go     = 1'b1;
                mul_a      = m_reg;
                mul_b      = m_reg;
                mul_tag    = epps_pkg::TAG_SQ;
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (mo.valid && mo.tag == epps_pkg::TAG_SQ)
                begin
                    if (sq[63])
                    begin
                        f_next = {f_reg[epps_pkg::LFRAC_BITS-2:0], 1'b1};
                        m_next = sq >> 1;
                    end
                    else
                    begin
                        f_next = {f_reg[epps_pkg::LFRAC_BITS-2:0], 1'b0};
                        m_next = sq;
                    end
                    bit_next   = bit_reg + 5'd1;
                    state_next = (bit_reg + 5'd1 == nbits) ? S_LFIN : S_LSQ;
                end
            end
            S_LFIN:
            begin
                if (!pass_reg)
                begin
                    res_next.interior = 1'b0;
                    res_next.lval     = lval;
                    if (lval == '0)
                    begin
                        res_next.shade = '0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        m_next     = {32'd0, lval};
                        p_next     = 6'd62;
                        f_next     = '0;
                        bit_next   = '0;
                        pass_next  = 1'b1;
                        state_next = S_NORM;
                    end
                end
                else
                begin
                    res_next.shade = epps_pkg::SHADE_TAB[f_reg[epps_pkg::SHADE_BITS-1:0]];
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iss_reg   <= 2'd0;
            bit_reg   <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            bit_reg   <= bit_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        mapx_reg  <= mapx_next;
        mapy_reg  <= mapy_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        rr_reg    <= rr_next;
        ii_reg    <= ii_next;
        ri_reg    <= ri_next;
        count_reg <= count_next;
        m_reg     <= m_next;
        p_reg     <= p_next;
        f_reg     <= f_next;
        res_reg   <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

/* hdl/escape_potential_pixel_shade_top.sv */
// One item at a time: after acceptance the states S_MAP1 and S_MAP2 map the pixel, then each
// iteration issues three products into the four-cell multiplier chain, waits for the last and
// checks for escape. An escaped point then takes two logarithms (one squaring through the chain
// for each fraction bit, after normalising by one place a cycle) before the result is handed
// over. An interior point skips the logarithms.
// Reset (rst_n, asynchronous, active low) idles the sequencer and loads register defaults.
module escape_potential_pixel_shade_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // pixel_x, pixel_y
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,   // escape_count, log2 of squared modulus, shade
    output logic                               m_tuser,   // inside_res
    input  logic                               cfg_we,
    input  logic [epps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [epps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    epps_pkg::cfg_t cfg_reg, cfg_next;
    logic           out_valid_reg, out_valid_next;
    epps_pkg::res_t out_reg, out_next;
    logic           core_idle;
    logic           core_valid;
    epps_pkg::res_t core_res;
    logic           take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                epps_pkg::REG_X_MIN:      cfg_next.x_min      = $signed(cfg_wdata[47:0]);
                epps_pkg::REG_Y_MAX:      cfg_next.y_max      = $signed(cfg_wdata[47:0]);
                epps_pkg::REG_STEP_X:     cfg_next.step_x     = cfg_wdata[46:0];
                epps_pkg::REG_STEP_Y:     cfg_next.step_y     = cfg_wdata[46:0];
                epps_pkg::REG_RADIUS_SQ:  cfg_next.radius_sq  = cfg_wdata[6:0];
                epps_pkg::REG_ITER_LIMIT: cfg_next.iter_limit = cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    assign s_tready = core_idle;

    epps_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (s_tvalid && core_idle),
        .px       (s_tdata[10:0]),
        .py       (s_tdata[21:11]),
        .idle     (core_idle),
        .res_valid(core_valid),
        .res      (core_res),
        .res_take (take)
    );

    // hold the result here so the sequencer can start the next item
    always_comb
    begin
        take           = core_valid && (!out_valid_reg || m_tready);
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min      <= epps_pkg::X_MIN_RST;
            cfg_reg.y_max      <= epps_pkg::Y_MAX_RST;
            cfg_reg.step_x     <= epps_pkg::STEP_RST;
            cfg_reg.step_y     <= epps_pkg::STEP_RST;
            cfg_reg.radius_sq  <= epps_pkg::RADIUS_RST;
            cfg_reg.iter_limit <= epps_pkg::LIMIT_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.shade, out_reg.lval, out_reg.count};
    assign m_tuser  = out_reg.interior;

endmodule
